### hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and sizes for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W = $clog2(DATA_WIDTH);

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic        [DATA_WIDTH-1:0]  data_u_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [ADDR_W-1:0]      addr_t;
    typedef logic        [CNT_W-1:0]       cnt_t;
    typedef logic        [DIV_CNT_W-1:0]   div_cnt_t;

    localparam cnt_t     CNT_ZERO  = cnt_t'(0);
    localparam cnt_t     CNT_ONE   = cnt_t'(1);
    localparam cnt_t     CNT_TWO   = cnt_t'(2);
    localparam cnt_t     CNT_FULL  = cnt_t'(STACK_DEPTH);
    localparam div_cnt_t DIV_LAST  = div_cnt_t'(DATA_WIDTH - 1);

    // token kinds
    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_LEFTOVER  = 3'd4
    } status_t;

    // stack update chosen for the current token
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_PUSH   = 2'd1,
        ACT_REDUCE = 2'd2
    } act_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // capture token
        logic exec;      // evaluate token, update sticky error
        logic mul;       // register product
        logic div_step;  // one restoring division step
        logic div_fix;   // apply quotient sign
        logic commit;    // write stack, load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/rpn_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_chan_if
// Token and result channels of the postfix stack evaluator.
// ----------------------------------------------------------------------------
interface rpn_tok_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] number;
    logic               end_of_expr;

    modport source (output valid, output cmd, output number, output end_of_expr,
                    input ready);
    modport sink   (input valid, input cmd, input number, input end_of_expr,
                    output ready);
endinterface

interface rpn_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               done_res;

    modport source (output valid, output value, output status, output done_res,
                    input ready);
    modport sink   (input valid, input value, input status, input done_res,
                    output ready);
endinterface

### hdl/postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix integer expression evaluator on a 16-entry operand stack.
//
// tok : token channel (cmd, number, end_of_expr), valid/ready.
// res : result channel (value, status, done_res), valid/ready; exactly one
//       result transaction per token transaction, in order.
// Tokens are processed one at a time. After acceptance, push, add, subtract
// and unused kinds are evaluated and committed; multiply adds a registered
// 32x32 product, and divide a 32-step restoring divider plus sign fix. The
// next token is taken in the cycle after the result is loaded; the divider
// loop sets the worst case for how long a token occupies the evaluator.
// The result sits in an output register; the next token is accepted and
// evaluated while it waits, and its commit holds until the register frees.
// Errors are sticky until the token flagged end_of_expr, which closes the
// expression and clears the stack and the error.
// Reset empties the stack and clears the error and both channel states;
// stack contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_top
(
    input  logic       clk,
    input  logic       rst_n,
    rpn_tok_if.sink    tok,
    rpn_res_if.source  res
);

    rpn_pkg::dp_cmd_t  dp_cmd;
    rpn_pkg::dp_stat_t dp_stat;
    logic              tok_ready;

    assign tok.ready = tok_ready;

    rpn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok.valid),
        .tok_ready (tok_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    rpn_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .tok_cmd    (tok.cmd),
        .tok_number (tok.number),
        .tok_end    (tok.end_of_expr),
        .res_ready  (res.ready),
        .res_valid  (res.valid),
        .res_value  (res.value),
        .res_status (res.status),
        .res_done   (res.done_res)
    );

endmodule

### hdl/rpn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer: one token at a time through evaluate, multiply or divide,
// and commit.
// ----------------------------------------------------------------------------
module rpn_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    output logic               tok_ready,
    input  rpn_pkg::dp_stat_t  stat,
    output rpn_pkg::dp_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DFIX = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tok_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                tok_ready  = 1'b1;
                cmd.accept = tok_valid;
                if (tok_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_mul)
                begin
                    state_next = S_MUL;
                end
                else if (stat.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DFIX;
                end
            end
            S_DFIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                // hold until the result register can take the transaction
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("rpn_ctrl: state register not one-hot");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == S_IDLE))
        else $error("rpn_ctrl: commit not followed by idle");
`endif

endmodule

### hdl/rpn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_datapath
// Operand stack, ALU, serial divider, sticky error and result register.
// ----------------------------------------------------------------------------
module rpn_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpn_pkg::dp_cmd_t    cmd,
    output rpn_pkg::dp_stat_t   stat,
    input  logic [2:0]          tok_cmd,
    input  logic signed [31:0]  tok_number,
    input  logic                tok_end,
    input  logic                res_ready,
    output logic                res_valid,
    output logic signed [31:0]  res_value,
    output logic [2:0]          res_status,
    output logic                res_done
);

    // operand stack
    rpn_pkg::data_t   mem [rpn_pkg::STACK_DEPTH];
    rpn_pkg::data_t   rd_l_reg;
    rpn_pkg::data_t   rd_r_reg;

    // control state
    rpn_pkg::cnt_t    cnt_reg;
    rpn_pkg::status_t sticky_reg;
    rpn_pkg::act_t    act_reg;
    logic             out_valid_reg;

    // token and work registers
    logic [2:0]           op_reg;
    rpn_pkg::data_t       num_reg;
    logic                 end_reg;
    rpn_pkg::data_t       res_reg;
    rpn_pkg::data_u_t     quo_reg;
    rpn_pkg::data_u_t     rem_reg;
    rpn_pkg::data_u_t     dvs_reg;
    logic                 neg_reg;
    rpn_pkg::div_cnt_t    step_reg;
    rpn_pkg::value_t      value_reg;
    rpn_pkg::status_t     status_reg;
    logic                 done_reg;

    rpn_pkg::cnt_t        cnt_m1;
    rpn_pkg::cnt_t        cnt_m2;
    rpn_pkg::cnt_t        cnt_new;
    rpn_pkg::addr_t       wr_idx;

    rpn_pkg::act_t        ev_act;
    rpn_pkg::status_t     ev_err;
    rpn_pkg::data_t       ev_res;
    logic                 ev_mul;
    logic                 ev_div;

    rpn_pkg::data_t       prod;
    logic [rpn_pkg::DATA_WIDTH:0] rem_shift;
    logic [rpn_pkg::DATA_WIDTH:0] rem_diff;
    rpn_pkg::data_u_t     mag_l;
    rpn_pkg::data_u_t     mag_r;
    rpn_pkg::data_u_t     quo_neg;

    rpn_pkg::data_t       fin_value;
    rpn_pkg::status_t     fin_status;

    assign cnt_m1 = cnt_reg - rpn_pkg::CNT_ONE;
    assign cnt_m2 = cnt_reg - rpn_pkg::CNT_TWO;

    // ---------------- token evaluation ----------------
    always_comb
    begin
        ev_act = rpn_pkg::ACT_NONE;
        ev_err = sticky_reg;
        ev_res = num_reg;
        ev_mul = 1'b0;
        ev_div = 1'b0;
        if (sticky_reg == rpn_pkg::ST_OK)
        begin
            if (op_reg == rpn_pkg::CMD_PUSH)
            begin
                if (cnt_reg >= rpn_pkg::CNT_FULL)
                begin
                    ev_err = rpn_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ev_act = rpn_pkg::ACT_PUSH;
                end
            end
            else if (op_reg inside {rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                                    rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV})
            begin
                if (cnt_reg < rpn_pkg::CNT_TWO)
                begin
                    ev_err = rpn_pkg::ST_UNDERFLOW;
                end
                else if (op_reg == rpn_pkg::CMD_DIV && rd_r_reg == '0)
                begin
                    ev_err = rpn_pkg::ST_DIVZERO;
                end
                else
                begin
                    ev_act = rpn_pkg::ACT_REDUCE;
                    ev_res = (op_reg == rpn_pkg::CMD_SUB) ? rd_l_reg - rd_r_reg
                                                          : rd_l_reg + rd_r_reg;
                    ev_mul = (op_reg == rpn_pkg::CMD_MUL);
                    ev_div = (op_reg == rpn_pkg::CMD_DIV);
                end
            end
        end
    end

    assign stat.need_mul = ev_mul;
    assign stat.need_div = ev_div;
    assign stat.div_last = (step_reg == rpn_pkg::DIV_LAST);
    assign stat.out_free = !out_valid_reg || res_ready;

    // ---------------- arithmetic ----------------
    assign prod      = rd_l_reg * rd_r_reg;
    assign mag_l     = rd_l_reg[rpn_pkg::DATA_WIDTH-1] ? rpn_pkg::data_u_t'(-rd_l_reg)
                                                       : rpn_pkg::data_u_t'(rd_l_reg);
    assign mag_r     = rd_r_reg[rpn_pkg::DATA_WIDTH-1] ? rpn_pkg::data_u_t'(-rd_r_reg)
                                                       : rpn_pkg::data_u_t'(rd_r_reg);
    assign rem_shift = {rem_reg, quo_reg[rpn_pkg::DATA_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign quo_neg   = ~quo_reg + rpn_pkg::data_u_t'(1);

    // ---------------- commit ----------------
    always_comb
    begin
        case (act_reg)
            rpn_pkg::ACT_PUSH:   cnt_new = cnt_reg + rpn_pkg::CNT_ONE;
            rpn_pkg::ACT_REDUCE: cnt_new = cnt_m1;
            default:             cnt_new = cnt_reg;
        endcase
        wr_idx = (act_reg == rpn_pkg::ACT_PUSH) ? cnt_reg[rpn_pkg::ADDR_W-1:0]
                                                : cnt_m2[rpn_pkg::ADDR_W-1:0];

        fin_status = sticky_reg;
        fin_value  = (act_reg == rpn_pkg::ACT_NONE) ? '0 : res_reg;
        if (sticky_reg != rpn_pkg::ST_OK)
        begin
            fin_value = '0;
        end
        else if (end_reg)
        begin
            if (cnt_new == rpn_pkg::CNT_ONE)
            begin
                // a token with no stack effect leaves the bottom entry on the read port
                fin_value = (act_reg == rpn_pkg::ACT_NONE) ? rd_r_reg : res_reg;
            end
            else
            begin
                fin_value  = '0;
                fin_status = (cnt_new == rpn_pkg::CNT_ZERO) ? rpn_pkg::ST_UNDERFLOW
                                                            : rpn_pkg::ST_LEFTOVER;
            end
        end
    end

    // ---------------- stack memory ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.commit && act_reg != rpn_pkg::ACT_NONE)
        begin
            mem[wr_idx] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_l_reg <= mem[cnt_m2[rpn_pkg::ADDR_W-1:0]];
        rd_r_reg <= mem[cnt_m1[rpn_pkg::ADDR_W-1:0]];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= rpn_pkg::CNT_ZERO;
            sticky_reg    <= rpn_pkg::ST_OK;
            act_reg       <= rpn_pkg::ACT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                sticky_reg <= ev_err;
                act_reg    <= ev_act;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (end_reg)
                begin
                    cnt_reg    <= rpn_pkg::CNT_ZERO;
                    sticky_reg <= rpn_pkg::ST_OK;
                end
                else
                begin
                    cnt_reg <= cnt_new;
                end
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= tok_cmd;
            num_reg <= rpn_pkg::data_t'(tok_number);
            end_reg <= tok_end;
        end
        if (cmd.exec)
        begin
            res_reg  <= ev_res;
            quo_reg  <= mag_l;
            rem_reg  <= '0;
            dvs_reg  <= mag_r;
            neg_reg  <= rd_l_reg[rpn_pkg::DATA_WIDTH-1] ^ rd_r_reg[rpn_pkg::DATA_WIDTH-1];
            step_reg <= '0;
        end
        if (cmd.mul)
        begin
            res_reg <= prod;
        end
        if (cmd.div_step)
        begin
            step_reg <= step_reg + rpn_pkg::div_cnt_t'(1);
            if (!rem_diff[rpn_pkg::DATA_WIDTH])
            begin
                rem_reg <= rem_diff[rpn_pkg::DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[rpn_pkg::DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[rpn_pkg::DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[rpn_pkg::DATA_WIDTH-2:0], 1'b0};
            end
        end
        if (cmd.div_fix)
        begin
            res_reg <= rpn_pkg::data_t'(neg_reg ? quo_neg : quo_reg);
        end
        if (cmd.commit)
        begin
            value_reg  <= rpn_pkg::value_t'(fin_value);
            status_reg <= fin_status;
            done_reg   <= end_reg;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_value  = value_reg;
    assign res_status = status_reg;
    assign res_done   = done_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rpn_pkg::CNT_FULL)
        else $error("rpn_datapath: stack count beyond depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && end_reg) |=>
            (cnt_reg == rpn_pkg::CNT_ZERO && sticky_reg == rpn_pkg::ST_OK))
        else $error("rpn_datapath: stack not cleared at end of expression");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || res_ready))
        else $error("rpn_datapath: result overwritten before taken");

    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) && status_reg != rpn_pkg::ST_OK |-> value_reg == '0)
        else $error("rpn_datapath: nonzero value with error status");
`endif

endmodule
